FILE: hw/rtl/irdt_pkg.sv
package irdt_pkg;

    localparam int TIMING_W = 24;
    localparam int SEEN_W   = 32;
    localparam int TOL_W    = 16;

    localparam logic [1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [1:0] FUNC_DECODED = 2'd1;
    localparam logic [1:0] FUNC_RAW     = 2'd2;

    localparam logic [1:0] STAT_MATCH   = 2'd0;
    localparam logic [1:0] STAT_ADDED   = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    localparam logic [TOL_W-1:0]  TOL_RESET = 16'd200;
    localparam logic [SEEN_W-1:0] SEEN_MAX  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]          func;
        logic [4:0]          protocol_id;
        logic [31:0]         address;
        logic [31:0]         command;
        logic [TIMING_W-1:0] timing;
        logic                last;
    } t_in_word;

    typedef struct packed {
        logic [4:0]        entry_index;
        logic [1:0]        status;
        logic [SEEN_W-1:0] seen_total;
        logic [5:0]        entry_count;
    } t_out_word;

endpackage

FILE: hw/rtl/ir_signal_dedup_table_top.sv
// Channel   Direction  Handshake                  Word
// input     in         i_in_valid / o_in_ready    irdt_pkg::t_in_word
// output    out        o_out_valid / i_out_ready  irdt_pkg::t_out_word
// config    in         i_cfg_we                   i_cfg_data (timing tolerance)
//
// Clear and raw timing words without the last mark are taken in the idle state and leave the block idle.
// A lookup scans the table memory one entry per cycle and stops at the first match.
// Reset is synchronous; it empties the table and the capture and sets the tolerance to 200.
// A finished result waits in the output register; the next word is taken meanwhile,
// and a further lookup holds in its last state until the output register is free.
module ir_signal_dedup_table_top #(
    parameter int TABLE_ENTRIES    = 32,
    parameter int MAX_TIMINGS      = 512,
    parameter int COMPARED_TIMINGS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  irdt_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output irdt_pkg::t_out_word            o_out_word,
    input  logic                           i_cfg_we,
    input  logic [irdt_pkg::TOL_W-1:0]     i_cfg_data
);

    localparam int IDXW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNTW  = $clog2(TABLE_ENTRIES + 1);
    localparam int TCW   = $clog2(MAX_TIMINGS + 1);
    localparam int CAPIW = (COMPARED_TIMINGS > 1) ? $clog2(COMPARED_TIMINGS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    typedef struct packed {
        logic                                                 is_raw;
        logic [4:0]                                           protocol;
        logic [31:0]                                          address;
        logic [31:0]                                          command;
        logic [TCW-1:0]                                       tcount;
        logic [COMPARED_TIMINGS-1:0][irdt_pkg::TIMING_W-1:0]  timings;
        logic [irdt_pkg::SEEN_W-1:0]                          seen;
    } t_row;

    t_row                          r_table [TABLE_ENTRIES];
    t_row                          r_rd_row;

    logic [1:0]                    r_state;
    logic [CNTW-1:0]               r_stored;
    logic [CNTW-1:0]               r_rd_idx;
    logic [IDXW-1:0]               r_chk_idx;
    logic                          r_chk_valid;
    logic [TCW-1:0]                r_cap_count;
    logic [irdt_pkg::TIMING_W-1:0] r_cap_tim [COMPARED_TIMINGS];
    logic [irdt_pkg::TOL_W-1:0]    r_tol;
    logic                          r_key_raw;
    logic [4:0]                    r_key_proto;
    logic [31:0]                   r_key_addr;
    logic [31:0]                   r_key_cmd;
    irdt_pkg::t_out_word           r_res;
    logic                          r_out_valid;
    irdt_pkg::t_out_word           r_out_word;

    logic                          in_fire;
    logic                          out_free;
    logic                          dec_hit;
    logic                          raw_hit;
    logic                          entry_hit;
    logic                          all_issued;
    logic                          full;
    logic                          rd_en;
    logic                          scan_done;
    logic                          wr_en;
    logic [IDXW-1:0]               wr_addr;
    t_row                          wr_row;
    t_row                          new_row;
    logic [irdt_pkg::SEEN_W-1:0]   seen_inc;
    irdt_pkg::t_out_word           n_res;
    logic [CNTW-1:0]               n_stored;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        logic [irdt_pkg::TIMING_W-1:0] a;
        logic [irdt_pkg::TIMING_W-1:0] b;
        logic [irdt_pkg::TIMING_W-1:0] d;
        logic                          ok;
        ok = 1'b1;
        for (int i = 0; i < COMPARED_TIMINGS; i++) begin
            a = r_rd_row.timings[i];
            b = r_cap_tim[i];
            d = (a > b) ? (a - b) : (b - a);
            if ((int'(r_cap_count) > i) && (d > irdt_pkg::TIMING_W'(r_tol))) begin
                ok = 1'b0;
            end
        end
        raw_hit = r_rd_row.is_raw && (r_rd_row.tcount == r_cap_count) && ok;
        dec_hit = !r_rd_row.is_raw && (r_rd_row.protocol == r_key_proto)
                  && (r_rd_row.address == r_key_addr) && (r_rd_row.command == r_key_cmd);
    end

    assign entry_hit  = r_chk_valid && (r_key_raw ? raw_hit : dec_hit);
    assign all_issued = (r_rd_idx == r_stored);
    assign full       = (r_stored == CNTW'(TABLE_ENTRIES));
    assign rd_en      = (r_state == ST_SCAN) && !all_issued && !entry_hit;
    assign scan_done  = (r_state == ST_SCAN) && (entry_hit || all_issued);
    assign seen_inc   = (r_rd_row.seen == irdt_pkg::SEEN_MAX) ? r_rd_row.seen
                                                              : r_rd_row.seen + 1'b1;

    always_comb begin
        new_row          = '0;
        new_row.is_raw   = r_key_raw;
        new_row.protocol = r_key_raw ? 5'd0 : r_key_proto;
        new_row.address  = r_key_raw ? 32'd0 : r_key_addr;
        new_row.command  = r_key_raw ? 32'd0 : r_key_cmd;
        new_row.tcount   = r_key_raw ? r_cap_count : '0;
        for (int i = 0; i < COMPARED_TIMINGS; i++) begin
            if (r_key_raw && (int'(r_cap_count) > i)) begin
                new_row.timings[i] = r_cap_tim[i];
            end
        end
        new_row.seen     = irdt_pkg::SEEN_W'(1);
    end

    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = r_chk_idx;
        wr_row   = r_rd_row;
        n_stored = r_stored;
        n_res    = '0;
        if (entry_hit) begin
            wr_en            = scan_done;
            wr_row.seen      = seen_inc;
            n_res.entry_index = 5'(r_chk_idx);
            n_res.status     = irdt_pkg::STAT_MATCH;
            n_res.seen_total = seen_inc;
        end else if (full) begin
            n_res.status     = irdt_pkg::STAT_FULL;
        end else begin
            wr_en            = scan_done;
            wr_addr          = r_stored[IDXW-1:0];
            wr_row           = new_row;
            n_stored         = r_stored + 1'b1;
            n_res.entry_index = 5'(r_stored);
            n_res.status     = irdt_pkg::STAT_ADDED;
            n_res.seen_total = irdt_pkg::SEEN_W'(1);
        end
        n_res.entry_count = 6'(n_stored);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            r_rd_row <= r_table[r_rd_idx[IDXW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (i_in_word.func == irdt_pkg::FUNC_RAW)
            && (int'(r_cap_count) < COMPARED_TIMINGS)) begin
            r_cap_tim[r_cap_count[CAPIW-1:0]] <= i_in_word.timing;
        end
        if (in_fire) begin
            r_key_raw   <= (i_in_word.func == irdt_pkg::FUNC_RAW);
            r_key_proto <= i_in_word.protocol_id;
            r_key_addr  <= i_in_word.address;
            r_key_cmd   <= i_in_word.command;
        end
        if (scan_done) begin
            r_res <= n_res;
        end
        if ((r_state == ST_DONE) && out_free) begin
            r_out_word <= r_res;
        end
        r_chk_idx <= r_rd_idx[IDXW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_stored    <= '0;
            r_rd_idx    <= '0;
            r_chk_valid <= 1'b0;
            r_cap_count <= '0;
            r_tol       <= irdt_pkg::TOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
            r_chk_valid <= rd_en;
            if (rd_en) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_rd_idx <= '0;
                    if (in_fire) begin
                        case (i_in_word.func)
                            irdt_pkg::FUNC_CLEAR: begin
                                r_stored    <= '0;
                                r_cap_count <= '0;
                            end
                            irdt_pkg::FUNC_DECODED: begin
                                r_state <= ST_SCAN;
                            end
                            irdt_pkg::FUNC_RAW: begin
                                if (int'(r_cap_count) < MAX_TIMINGS) begin
                                    r_cap_count <= r_cap_count + 1'b1;
                                end
                                if (i_in_word.last) begin
                                    r_state <= ST_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (scan_done) begin
                        r_stored <= n_stored;
                        if (r_key_raw) begin
                            r_cap_count <= '0;
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/irdt_checker.sv
module irdt_checker #(
    parameter int TABLE_ENTRIES = 32
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input irdt_pkg::t_out_word o_out_word
);

    // A waiting result word stays until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed or dropped while stalled");

    // A dropped signal reports a full table, slot zero and no count.
    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == irdt_pkg::STAT_FULL) |->
            (o_out_word.entry_index == 5'd0) && (o_out_word.seen_total == '0)
            && (o_out_word.entry_count == 6'(TABLE_ENTRIES)))
        else $error("full-table word is inconsistent");

    // A new entry lands in the slot just below the new entry count.
    a_added_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == irdt_pkg::STAT_ADDED) |->
            (o_out_word.seen_total == 32'd1)
            && (o_out_word.entry_count[4:0] == o_out_word.entry_index + 5'd1))
        else $error("added-entry word is inconsistent");

    // A matched entry always has a nonzero count in a nonempty table.
    a_match_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == irdt_pkg::STAT_MATCH) |->
            (o_out_word.seen_total != '0) && (o_out_word.entry_count != 6'd0
            || TABLE_ENTRIES >= 64))
        else $error("matched word is inconsistent");

endmodule

bind ir_signal_dedup_table_top irdt_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
) u_irdt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
